// ===== rtl/akme_pkg.sv =====
// akme_pkg: shared types and constants of the keyed MAC engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package akme_pkg;

    // Block geometry: 64-byte blocks of eight 64-bit slots, 32-byte tag
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned TAG_BYTES   = 32;
    localparam int unsigned SLOTS       = BLOCK_BYTES / 8;
    localparam int unsigned TAG_CHUNKS  = TAG_BYTES / 8;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY0   = 3'd0;
    localparam logic [2:0] CFG_KEY1   = 3'd1;
    localparam logic [2:0] CFG_KEY2   = 3'd2;
    localparam logic [2:0] CFG_KEY3   = 3'd3;
    localparam logic [2:0] CFG_ROUNDS = 3'd4;

    localparam logic [7:0] ROUNDS_RESET = 8'd32;

    // Fixed words loaded into rows 2-3 at the start of a message
    localparam logic [7:0][31:0] INIT_CONSTS = {
        32'hec05e8fb, 32'hf64a2a14, 32'h9aa44f2e, 32'hefda0713,
        32'h923481c0, 32'hc318af38, 32'hc6685b1d, 32'he2522dcb
    };

    // 4x4 matrix of 32-bit words, word r*4+c at index r*4+c
    typedef logic [15:0][31:0] t_mat;

    // Configuration seen by the mixing engine
    typedef struct packed {
        logic [3:0][63:0] key;
        logic [7:0]       rounds;
    } t_cfg;

    // Classified chunk passed from front to back
    typedef struct packed {
        logic [63:0] data;     // masked message bytes
        logic        occupy;   // takes a slot in the block
        logic        first;
        logic        last;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/akme_front.sv =====
// akme_front: masks the input chunk and classifies it into a command.
// Depends on akme_pkg.
`default_nettype none

module akme_front (
    input  wire logic [63:0]  i_chunk,
    input  wire logic [3:0]   i_nbytes,
    input  wire logic         i_first,
    input  wire logic         i_last,
    output akme_pkg::t_cmd    o_cmd
);
    import akme_pkg::*;

    logic [3:0]  nb_clamp;
    logic [63:0] keep_mask;

    // Clamp byte count to eight
    assign nb_clamp = (i_nbytes > 4'd8) ? 4'd8 : i_nbytes;

    // Keep the leading bytes only
    always_comb begin
        keep_mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < nb_clamp) begin
                keep_mask[63 - 8*b -: 8] = 8'hff;
            end
        end
    end

    // An empty last chunk only closes the message
    always_comb begin
        o_cmd.data   = i_chunk & keep_mask;
        o_cmd.occupy = !(i_last && (nb_clamp == 4'd0));
        o_cmd.first  = i_first;
        o_cmd.last   = i_last;
    end

endmodule

`default_nettype wire

// ===== rtl/akme_queue.sv =====
// akme_queue: two-entry command queue between front and back.
// Depends on akme_pkg.
`default_nettype none

module akme_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire akme_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output akme_pkg::t_cmd       o_cmd
);
    import akme_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage, no reset on payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            if (do_push && !do_pop)      r_count <= r_count + 2'd1;
            else if (do_pop && !do_push) r_count <= r_count - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/akme_back.sv =====
// akme_back: matrix state, absorb step, two-phase round engine, tag output.
// Depends on akme_pkg.
`default_nettype none

module akme_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire akme_pkg::t_cfg  i_cfg,
    input  wire logic            i_q_empty,
    input  wire akme_pkg::t_cmd  i_cmd,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [63:0]          o_data,
    output logic                 o_last
);
    import akme_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RA   = 2'd1;
    localparam logic [1:0] ST_RB   = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Column add in place, then rows shift up by one
    function automatic t_mat col_shift(input t_mat m);
        t_mat c;
        t_mat s;
        c = m;
        for (int i = 0; i < 12; i++) c[i] = m[i] + m[i + 4];
        for (int i = 12; i < 16; i++) c[i] = m[i] + c[i - 12];
        for (int i = 0; i < 16; i++) s[i] = c[(i + 4) % 16];
        return s;
    endfunction

    // Indexed in-place adds, row 0 rotates, snapshot add
    function automatic t_mat round_fin(input t_mat m, input t_mat snap);
        t_mat a;
        a = m;
        a[0]  = a[0]  + a[14];
        a[1]  = a[1]  + a[12];
        a[2]  = a[2]  + a[6];
        a[3]  = a[3]  + a[11];
        a[4]  = a[4]  + a[1];
        a[5]  = a[5]  + a[13];
        a[6]  = a[6]  + a[9];
        a[7]  = a[7]  + a[0];
        a[8]  = a[8]  + a[2];
        a[9]  = a[9]  + a[7];
        a[10] = a[10] + a[15];
        a[11] = a[11] + a[5];
        a[12] = a[12] + a[3];
        a[13] = a[13] + a[4];
        a[14] = a[14] + a[10];
        a[15] = a[15] + a[8];
        a[0]  = {a[0][25:0], a[0][31:26]};
        a[1]  = {a[1][10:0], a[1][31:11]};
        a[2]  = {a[2][21:0], a[2][31:22]};
        a[3]  = {a[3][28:0], a[3][31:29]};
        for (int i = 0; i < 16; i++) a[i] = a[i] + snap[i];
        return a;
    endfunction

    logic [1:0] r_state, n_state;
    t_mat       r_mat, n_mat;
    t_mat       r_snap;
    logic [2:0] r_pos, n_pos;
    logic       r_pending, n_pending;
    logic [7:0] r_rounds, n_rounds;
    logic       r_emit, n_emit;
    logic [1:0] r_tag_idx, n_tag_idx;

    t_mat       mat_init, mat_abs;
    logic [2:0] pos_eff, pos_inc;
    logic       pend, do_mix, take;

    assign take    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_q_pop = take;

    // Absorb: optional message start, then XOR into the current slot
    always_comb begin
        mat_init = r_mat;
        if (i_cmd.first) begin
            for (int k = 0; k < 4; k++) begin
                mat_init[2*k]     = i_cfg.key[k][63:32];
                mat_init[2*k + 1] = i_cfg.key[k][31:0];
            end
            for (int k = 0; k < 8; k++) mat_init[8 + k] = INIT_CONSTS[k];
        end
        pos_eff = i_cmd.first ? 3'd0 : r_pos;
        pos_inc = pos_eff + 3'd1;
        mat_abs = mat_init;
        if (i_cmd.occupy) begin
            for (int s = 0; s < 8; s++) begin
                if (3'(s) == pos_eff) begin
                    mat_abs[2*s]     = mat_init[2*s] ^ i_cmd.data[63:32];
                    mat_abs[2*s + 1] = mat_init[2*s + 1] ^ i_cmd.data[31:0];
                end
            end
        end
        pend   = i_cmd.first || r_pending || i_cmd.occupy;
        do_mix = (i_cmd.occupy && (pos_inc == 3'd0)) || (i_cmd.last && pend);
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_mat     = r_mat;
        n_pos     = r_pos;
        n_pending = r_pending;
        n_rounds  = r_rounds;
        n_emit    = r_emit;
        n_tag_idx = r_tag_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_mat     = mat_abs;
                    n_pending = do_mix ? 1'b0 : pend;
                    n_pos     = i_cmd.last ? 3'd0 : (i_cmd.occupy ? pos_inc : pos_eff);
                    n_emit    = i_cmd.last;
                    n_rounds  = i_cfg.rounds;
                    n_tag_idx = 2'd0;
                    if (do_mix && (i_cfg.rounds != 8'd0)) begin
                        n_state = ST_RA;
                    end else if (i_cmd.last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_RA: begin
                n_mat   = col_shift(r_mat);
                n_state = ST_RB;
            end
            ST_RB: begin
                n_mat    = round_fin(r_mat, r_snap);
                n_rounds = r_rounds - 8'd1;
                if (r_rounds == 8'd1) begin
                    n_state = r_emit ? ST_EMIT : ST_IDLE;
                end else begin
                    n_state = ST_RA;
                end
            end
            ST_EMIT: begin
                if (i_ready) begin
                    n_tag_idx = r_tag_idx + 2'd1;
                    if (r_tag_idx == 2'(TAG_CHUNKS - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Snapshot of the matrix at the start of each round
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RA) begin
            r_snap <= r_mat;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mat     <= '0;
            r_pos     <= 3'd0;
            r_pending <= 1'b0;
            r_rounds  <= 8'd0;
            r_emit    <= 1'b0;
            r_tag_idx <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_mat     <= n_mat;
            r_pos     <= n_pos;
            r_pending <= n_pending;
            r_rounds  <= n_rounds;
            r_emit    <= n_emit;
            r_tag_idx <= n_tag_idx;
        end
    end

    // Tag beats come straight from the held matrix
    assign o_valid = (r_state == ST_EMIT);
    assign o_data  = {r_mat[{1'b0, r_tag_idx, 1'b0}], r_mat[{1'b0, r_tag_idx, 1'b1}]};
    assign o_last  = (r_tag_idx == 2'(TAG_CHUNKS - 1));

endmodule

`default_nettype wire

// ===== rtl/arx_keyed_mac_engine.sv =====
// arx_keyed_mac_engine: top level, configuration registers and wiring.
// Depends on akme_pkg, akme_front, akme_queue, akme_back.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: message_chunk, chunk_bytes; tuser: first_chunk;
//                       tlast: last_chunk
//  m_axis    out        tdata: tag_chunk; tlast: tag_last
//  cfg       in         i_cfg_we / i_cfg_index / i_cfg_wdata, write only
//
// The engine takes in one chunk per cycle while it is idle. A chunk that
// closes a block, or the last chunk of a message with a pending block,
// starts round_count rounds (one round is a column-add phase and a finish
// phase). The last chunk then sends four tag beats, one per cycle while
// m_axis_tready is high. A two-entry queue lets the input side take chunks
// while the engine mixes or waits on m_axis.
// Reset is synchronous, active low; no clearing pass is needed.
`default_nettype none

module arx_keyed_mac_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // [63:0] message_chunk, [67:64] chunk_bytes
    input  wire logic        s_axis_tuser,   // [0] first_chunk
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] tag_chunk
    output logic             m_axis_tlast
);
    import akme_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    logic q_full, q_empty, q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key    <= '0;
            r_cfg.rounds <= ROUNDS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY0:   r_cfg.key[0] <= i_cfg_wdata;
                CFG_KEY1:   r_cfg.key[1] <= i_cfg_wdata;
                CFG_KEY2:   r_cfg.key[2] <= i_cfg_wdata;
                CFG_KEY3:   r_cfg.key[3] <= i_cfg_wdata;
                CFG_ROUNDS: r_cfg.rounds <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;

    akme_front u_front (
        .i_chunk  (s_axis_tdata[63:0]),
        .i_nbytes (s_axis_tdata[67:64]),
        .i_first  (s_axis_tuser),
        .i_last   (s_axis_tlast),
        .o_cmd    (front_cmd)
    );

    akme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    akme_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/akme_checker.sv =====
// akme_checker: port-level assertions for arx_keyed_mac_engine, with bind.
// Depends on nothing but the top level's port names.
`default_nettype none

module akme_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic        m_axis_tlast
);

    logic [1:0] r_beat;
    logic       out_req;

    assign out_req = m_axis_tvalid && m_axis_tready;

    // Count tag beats within one tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= 2'd0;
        end else if (out_req) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    // A stalled tag beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("tag beat changed while stalled");

    // Reset leaves no tag beat pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("tag valid right after reset");

    // tlast marks exactly the fourth beat of each tag
    a_tag_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req |-> (m_axis_tlast == (r_beat == 2'd3)))
        else $error("tag length not four beats");

    // The tag stream pauses after each tag
    a_tag_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req && m_axis_tlast |=> !m_axis_tvalid)
        else $error("tag beat right after a final beat");

endmodule

bind arx_keyed_mac_engine akme_checker u_akme_checker (.*);

`default_nettype wire
